FILE: sv/ale_pkg.sv
// shared types and codes for the array list engine
package ale_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned DataW   = 32;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_CHANGE = 3'd4,
    OP_REMOVE = 3'd5,
    OP_DEDUPE = 3'd6,
    OP_READ   = 3'd7
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK       = 2'd0,
    STS_NOTFOUND = 2'd1,
    STS_FULL     = 2'd2,
    STS_RANGE    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_INS,
    S_DEL,
    S_FIND,
    S_RMV,
    S_DDK,
    S_DDS
  } state_e;

endpackage

FILE: sv/ale_ram.sv
// generic single write port, single read port ram with registered read
module ale_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/array_list_engine_unit.sv
// array list engine: ordered list of signed words kept in one element ram
// append, empty dedupe and early errors finish straight from idle, read goes through S_READ; delete, search and
//   change, insert and remove-all walk the list one entry per cycle through the single read port; dedupe
//   fetches each entry in turn and then scans the later entries for a copy of it
// throughput: one transaction at a time, start is taken whenever busy is low
// reset clears the list length and control state; the element ram is not cleared
// each result shows for exactly one cycle on done_o; the receiver cannot stall
module array_list_engine_unit #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start,
  output logic                                      busy,
  input  logic [ale_pkg::OpW-1:0]                   opcode_i,
  input  logic signed [ale_pkg::DataW-1:0]          value_i,
  input  logic signed [ale_pkg::DataW-1:0]          new_value_i,
  input  logic [$clog2(DEPTH+1)-1:0]                position_i,
  output logic                                      done_o,
  output logic [ale_pkg::StatusW-1:0]               status_o,
  output logic [$clog2(DEPTH)-1:0]                  found_index_o,
  output logic signed [ale_pkg::DataW-1:0]          read_value_o,
  output logic [$clog2(DEPTH+1)-1:0]                list_length_o,
  output logic [$clog2(DEPTH+1)-1:0]                removed_count_o
);

  import ale_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // control state
  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;        // list length
  logic           pv_q, pv_d;          // a ram read is in flight
  logic           rg_q, rg_d;          // more entries left to read in this walk
  logic           done_q, done_d;

  // transaction and walk registers
  op_e            op_q, op_d;
  logic [31:0]    val_q, val_d;
  logic [31:0]    nval_q, nval_d;
  logic [31:0]    key_q, key_d;        // dedupe: entry under test
  logic [CW-1:0]  pos_q, pos_d;
  logic [CW-1:0]  rd_q, rd_d;          // next read address
  logic [CW-1:0]  pa_q, pa_d;          // address of the read in flight
  logic [CW-1:0]  wp_q, wp_d;          // compaction write pointer
  logic [CW-1:0]  oi_q, oi_d;          // dedupe outer index

  // result registers
  status_e        status_q, status_d;
  logic [AW-1:0]  fidx_q, fidx_d;
  logic [31:0]    rval_q, rval_d;
  logic [CW-1:0]  len_q, len_d;
  logic [CW-1:0]  rem_q, rem_d;

  // finish strobe and result fields from the sequencer
  logic           fin;
  status_e        f_status;
  logic [AW-1:0]  f_fidx;
  logic [31:0]    f_rval;
  logic [CW-1:0]  f_rem;

  // element ram port
  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [31:0]    wdata, rdata;

  logic           hit, dd_hit;
  logic [CW-1:0]  pa_inc, pa_dec, rd_inc, oi_inc, pos_inc;

  ale_ram #(
    .Width(32),
    .Depth(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign hit     = (rdata == val_q);
  assign dd_hit  = (rdata == key_q);
  assign pa_inc  = pa_q + CW'(1);
  assign pa_dec  = pa_q - CW'(1);
  assign rd_inc  = rd_q + CW'(1);
  assign oi_inc  = oi_q + CW'(1);
  assign pos_inc = position_i + CW'(1);

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pv_d     = pv_q;
    rg_d     = rg_q;
    op_d     = op_q;
    val_d    = val_q;
    nval_d   = nval_q;
    key_d    = key_q;
    pos_d    = pos_q;
    rd_d     = rd_q;
    pa_d     = pa_q;
    wp_d     = wp_q;
    oi_d     = oi_q;
    done_d   = 1'b0;
    status_d = status_q;
    fidx_d   = fidx_q;
    rval_d   = rval_q;
    len_d    = len_q;
    rem_d    = rem_q;
    fin      = 1'b0;
    f_status = STS_OK;
    f_fidx   = '0;
    f_rval   = '0;
    f_rem    = '0;
    we       = 1'b0;
    waddr    = cnt_q[AW-1:0];
    wdata    = val_q;
    re       = 1'b0;
    raddr    = rd_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d   = op_e'(opcode_i);
          val_d  = value_i;
          nval_d = new_value_i;
          pos_d  = position_i;
          pv_d   = 1'b0;
          case (op_e'(opcode_i))
            OP_APPEND: begin
              fin = 1'b1;
              if (cnt_q >= CW'(DEPTH)) begin
                f_status = STS_FULL;
              end else begin
                we    = 1'b1;
                waddr = cnt_q[AW-1:0];
                wdata = value_i;
                cnt_d = cnt_q + CW'(1);
              end
            end
            OP_INSERT: begin
              if (cnt_q >= CW'(DEPTH)) begin
                fin      = 1'b1;
                f_status = STS_FULL;
              end else if (position_i > cnt_q) begin
                fin      = 1'b1;
                f_status = STS_RANGE;
              end else if (position_i == cnt_q) begin
                // insert at the end is an append
                fin   = 1'b1;
                we    = 1'b1;
                waddr = cnt_q[AW-1:0];
                wdata = value_i;
                cnt_d = cnt_q + CW'(1);
              end else begin
                rd_d    = cnt_q - CW'(1);
                rg_d    = 1'b1;
                state_d = S_INS;
              end
            end
            OP_DELETE: begin
              if (position_i >= cnt_q) begin
                fin      = 1'b1;
                f_status = STS_RANGE;
              end else begin
                rd_d    = pos_inc;
                rg_d    = (pos_inc < cnt_q);
                state_d = S_DEL;
              end
            end
            OP_SEARCH, OP_CHANGE: begin
              rd_d    = '0;
              rg_d    = (cnt_q != '0);
              state_d = S_FIND;
            end
            OP_REMOVE: begin
              rd_d    = '0;
              rg_d    = (cnt_q != '0);
              wp_d    = '0;
              state_d = S_RMV;
            end
            OP_DEDUPE: begin
              if (cnt_q == '0) begin
                fin = 1'b1;
              end else begin
                oi_d    = '0;
                wp_d    = '0;
                state_d = S_DDK;
              end
            end
            OP_READ: begin
              if (position_i >= cnt_q) begin
                fin      = 1'b1;
                f_status = STS_RANGE;
              end else begin
                re      = 1'b1;
                raddr   = position_i[AW-1:0];
                state_d = S_READ;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        fin     = 1'b1;
        f_rval  = rdata;
        state_d = S_IDLE;
      end

      // shift up: read downward from the tail, write each entry one place higher
      S_INS: begin
        if (pv_q) begin
          we    = 1'b1;
          waddr = pa_inc[AW-1:0];
          wdata = rdata;
        end
        if (rg_q) begin
          re    = 1'b1;
          raddr = rd_q[AW-1:0];
          pa_d  = rd_q;
          pv_d  = 1'b1;
          rd_d  = rd_q - CW'(1);
          rg_d  = (rd_q != pos_q);
        end else begin
          pv_d = 1'b0;
        end
        if (!rg_q && !pv_q) begin
          we      = 1'b1;
          waddr   = pos_q[AW-1:0];
          wdata   = val_q;
          cnt_d   = cnt_q + CW'(1);
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end

      // shift down: read upward past the hole, write each entry one place lower
      S_DEL: begin
        if (pv_q) begin
          we    = 1'b1;
          waddr = pa_dec[AW-1:0];
          wdata = rdata;
        end
        if (rg_q) begin
          re    = 1'b1;
          raddr = rd_q[AW-1:0];
          pa_d  = rd_q;
          pv_d  = 1'b1;
          rd_d  = rd_inc;
          rg_d  = (rd_inc < cnt_q);
        end else begin
          pv_d = 1'b0;
        end
        if (!rg_q && !pv_q) begin
          cnt_d   = cnt_q - CW'(1);
          f_rem   = CW'(1);
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end

      // first match walk for search and change
      S_FIND: begin
        if (pv_q && hit) begin
          if (op_q == OP_CHANGE) begin
            we    = 1'b1;
            waddr = pa_q[AW-1:0];
            wdata = nval_q;
          end
          f_fidx  = pa_q[AW-1:0];
          fin     = 1'b1;
          pv_d    = 1'b0;
          state_d = S_IDLE;
        end else if (!rg_q) begin
          f_status = STS_NOTFOUND;
          fin      = 1'b1;
          pv_d     = 1'b0;
          state_d  = S_IDLE;
        end else begin
          re    = 1'b1;
          raddr = rd_q[AW-1:0];
          pa_d  = rd_q;
          pv_d  = 1'b1;
          rd_d  = rd_inc;
          rg_d  = (rd_inc < cnt_q);
        end
      end

      // compaction: keep entries that differ from the value to remove
      S_RMV: begin
        if (pv_q && !hit) begin
          we    = 1'b1;
          waddr = wp_q[AW-1:0];
          wdata = rdata;
          wp_d  = wp_q + CW'(1);
        end
        if (rg_q) begin
          re    = 1'b1;
          raddr = rd_q[AW-1:0];
          pv_d  = 1'b1;
          rd_d  = rd_inc;
          rg_d  = (rd_inc < cnt_q);
        end else begin
          pv_d = 1'b0;
        end
        if (!rg_q && !pv_q) begin
          cnt_d   = wp_q;
          f_rem   = cnt_q - wp_q;
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end

      // dedupe: fetch the entry under test
      S_DDK: begin
        if (!pv_q) begin
          re    = 1'b1;
          raddr = oi_q[AW-1:0];
          pv_d  = 1'b1;
        end else begin
          key_d   = rdata;
          pv_d    = 1'b0;
          rd_d    = oi_inc;
          rg_d    = (oi_inc < cnt_q);
          state_d = S_DDS;
        end
      end

      // dedupe: look for a later copy; keep the entry only if there is none
      S_DDS: begin
        if ((pv_q && dd_hit) || !rg_q) begin
          pv_d = 1'b0;
          if (!(pv_q && dd_hit)) begin
            we    = 1'b1;
            waddr = wp_q[AW-1:0];
            wdata = key_q;
            wp_d  = wp_q + CW'(1);
          end
          oi_d = oi_inc;
          if (oi_inc == cnt_q) begin
            cnt_d   = wp_d;
            f_rem   = cnt_q - wp_d;
            fin     = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_DDK;
          end
        end else begin
          re    = 1'b1;
          raddr = rd_q[AW-1:0];
          pv_d  = 1'b1;
          rd_d  = rd_inc;
          rg_d  = (rd_inc < cnt_q);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // load the result registers when a transaction completes
    if (fin) begin
      done_d   = 1'b1;
      status_d = f_status;
      fidx_d   = f_fidx;
      rval_d   = f_rval;
      len_d    = cnt_d;
      rem_d    = f_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      rg_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      rg_q    <= rg_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    nval_q   <= nval_d;
    key_q    <= key_d;
    pos_q    <= pos_d;
    rd_q     <= rd_d;
    pa_q     <= pa_d;
    wp_q     <= wp_d;
    oi_q     <= oi_d;
    status_q <= status_d;
    fidx_q   <= fidx_d;
    rval_q   <= rval_d;
    len_q    <= len_d;
    rem_q    <= rem_d;
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign found_index_o   = fidx_q;
  assign read_value_o    = rval_q;
  assign list_length_o   = len_q;
  assign removed_count_o = rem_q;

  // list length never exceeds the store
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("list length beyond store depth");

  // an append always completes in the following cycle
  a_append_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_APPEND)) |=> done_o)
    else $error("append did not complete in one cycle");

  // a result is only shown once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // a ram write during a walk other than insert never lands at or above the old length
  a_wr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && (state_q != S_IDLE) && (state_q != S_INS)) |-> ({1'b0, waddr} < (AW+1)'(cnt_q)))
    else $error("write past list end");

endmodule
